// ===== hw/rtl/mdcnp_pkg.sv =====
// Shared constants, types and helper functions for the microphone DC notch
// and pre-emphasis block. Used by every module of the block; depends on nothing.
package mdcnp_pkg;

    // Channel count and state store indexing.
    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths fixed by the interface.
    localparam int CH_W    = 3;
    localparam int RAW_W   = 16;
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 16;
    localparam int COEF15_W = 15;

    // Internal Q4.27 state word and the widened sample.
    localparam int STATE_W = 32;
    localparam int X_SHIFT = 12;
    localparam int X_W     = RAW_W + X_SHIFT;

    // Digit-serial multiplier geometry: 16-bit coefficient, 4-bit digits.
    localparam int DIGIT_W   = 4;
    localparam int DIGITS    = 4;
    localparam int COEF_W    = DIGIT_W * DIGITS;
    localparam int DCNT_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int OPND_W    = STATE_W + 1;
    localparam int PROD_W    = OPND_W + DIGIT_W + 1;
    localparam int HI_W      = PROD_W - DIGIT_W;
    localparam int RND_SHIFT = 15;
    localparam int RND_W     = HI_W + COEF_W - RND_SHIFT + 1;

    // Widths used in the finishing stages.
    localparam int SAT_IN_W = PROD_W;
    localparam int Z_SHIFT  = 7;
    localparam int O_W      = STATE_W - Z_SHIFT + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENOM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREEMPH = 2'd2;

    // Per-channel filter state.
    typedef struct packed {
        logic signed [STATE_W-1:0] a;
        logic signed [STATE_W-1:0] b;
        logic signed [STATE_W-1:0] prev;
    } t_ch_state;

    // State write request from the sequencer to the state store.
    typedef struct packed {
        logic            we_notch;
        logic            we_pre;
        logic [CH_W-1:0] ch;
        t_ch_state       data;
    } t_st_wr;

    // Saturate a wide signed value to the signed state range.
    function automatic logic signed [STATE_W-1:0] f_sat_state(
        input logic signed [SAT_IN_W-1:0] v
    );
        logic [SAT_IN_W-STATE_W:0] hi;
        logic signed [STATE_W-1:0] res;
        hi = v[SAT_IN_W-1:STATE_W-1];
        if ((&hi) || (~|hi)) begin
            res = v[STATE_W-1:0];
        end else if (v[SAT_IN_W-1]) begin
            res = {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(STATE_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/mdcnp_dmul.sv =====
// Digit-serial signed-by-unsigned multiplier with round-half-up by 2^15.
// Depends on mdcnp_pkg for its widths.
module mdcnp_dmul import mdcnp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic                     i_step,
    input  logic signed [OPND_W-1:0] i_opnd,
    input  logic [COEF_W-1:0]        i_coef,
    output logic signed [RND_W-1:0]  o_round
);

    logic signed [OPND_W-1:0]  r_opnd;
    logic [COEF_W-1:0]         r_coef;
    logic signed [HI_W-1:0]    r_hi;
    logic [COEF_W-1:0]         r_lo;

    logic [DIGIT_W-1:0]        w_digit;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [PROD_W-1:0]  w_t;
    logic signed [HI_W+COEF_W-RND_SHIFT-1:0] w_floor;

    // One coefficient digit per cycle while i_step is high, least significant first.
    always_comb begin
        w_digit = r_coef[DIGIT_W-1:0];
        w_prod  = r_opnd * $signed({1'b0, w_digit});
        w_t     = PROD_W'(r_hi) + w_prod;
    end

    // Upper part stays in the accumulator; the finished low digit shifts out.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_opnd <= i_opnd;
            r_coef <= i_coef;
            r_hi   <= '0;
            r_lo   <= '0;
        end else if (i_step) begin
            r_hi   <= w_t[PROD_W-1:DIGIT_W];
            r_lo   <= {w_t[DIGIT_W-1:0], r_lo[COEF_W-1:DIGIT_W]};
            r_coef <= r_coef >> DIGIT_W;
        end
    end

    // Rounding half up adds the first discarded bit to the floor.
    always_comb begin
        w_floor = {r_hi, r_lo[COEF_W-1:RND_SHIFT]};
        o_round = RND_W'(w_floor)
                + $signed({{(RND_W-1){1'b0}}, r_lo[RND_SHIFT-1]});
    end

endmodule

// ===== hw/rtl/mdcnp_chstate.sv =====
// Per-channel filter state store: notch memory and previous pre-emphasis input.
// Depends on mdcnp_pkg for the state types and channel count.
module mdcnp_chstate import mdcnp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [CH_W-1:0] i_rd_ch,
    output t_ch_state       o_rd,
    output logic            o_rd_ok,
    input  t_st_wr          i_wr
);

    t_ch_state r_mem [CHANNELS];

    logic [CH_IDX_W-1:0] w_rd_idx;
    logic [CH_IDX_W-1:0] w_wr_idx;

    // A channel beyond the store reads as all-zero state.
    always_comb begin
        w_rd_idx = CH_IDX_W'(i_rd_ch);
        o_rd_ok  = (int'(i_rd_ch) < CHANNELS);
        o_rd     = o_rd_ok ? r_mem[w_rd_idx] : '0;
    end

    assign w_wr_idx = CH_IDX_W'(i_wr.ch);

    // Reset clears every channel; writes update only the enabled stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_mem[i] <= '0;
            end
        end else begin
            if (i_wr.we_notch) begin
                r_mem[w_wr_idx].a <= i_wr.data.a;
                r_mem[w_wr_idx].b <= i_wr.data.b;
            end
            if (i_wr.we_pre) begin
                r_mem[w_wr_idx].prev <= i_wr.data.prev;
            end
        end
    end

endmodule

// ===== hw/rtl/mic_dc_notch_preemphasis.sv =====
// Top level of the microphone DC notch and pre-emphasis conditioner.
// Depends on mdcnp_pkg, mdcnp_dmul and mdcnp_chstate.
//
// Usage: one 16-bit sample with its channel tag enters on the input channel
// (i_in_valid / o_in_stall) and one Q3.20 result leaves on the output channel
// (o_out_valid / i_out_stall). An item moves at a clock edge where valid is
// high and stall is low. Configuration is written through i_cfg_we,
// i_cfg_index and i_cfg_data while no item is in flight.
// Flow: an item is accepted only while the block is idle, so a new item is
// taken only after the previous result has been loaded into the output
// register. After the accept the three products run in parallel on
// digit-serial multipliers, one 4-bit digit of the 16-bit coefficients per
// cycle, and then the item passes through four finishing stages.
// Stall: while a result waits in the output register the next item is still
// accepted and computed; it waits in its last stage until the output
// register frees.
// Reset: synchronous, active low; clears all channel state, the
// configuration registers (both stages bypassed) and the output valid.
module mic_dc_notch_preemphasis import mdcnp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CH_W-1:0]          i_mic_channel,
    input  logic signed [RAW_W-1:0]  i_raw_sample,
    input  logic                     i_block_last,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [CH_W-1:0]          o_out_channel,
    output logic signed [OUT_W-1:0]  o_clean_sample,
    output logic                     o_clipped,
    output logic                     o_out_block_last
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_FIN1 = 6'b000100,
        S_FIN2 = 6'b001000,
        S_FIN3 = 6'b010000,
        S_FIN4 = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic [DCNT_W-1:0] r_dcnt;

    logic [COEF15_W-1:0] r_radius;
    logic [CFG_W-1:0]    r_denom;
    logic [COEF15_W-1:0] r_preemph;

    logic [CH_W-1:0]          r_ch;
    logic                     r_last;
    logic                     r_chv;
    logic signed [X_W-1:0]    r_x;
    logic signed [OPND_W-1:0] r_bx;
    logic signed [RND_W-1:0]  r_yr;
    logic signed [RND_W-1:0]  r_dr;
    logic signed [RND_W-1:0]  r_pr;
    logic signed [STATE_W-1:0] r_na;
    logic signed [STATE_W-1:0] r_nb;
    logic signed [STATE_W-1:0] r_y;
    logic signed [STATE_W-1:0] r_z;

    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_ch;
    logic signed [OUT_W-1:0]  r_out_sample;
    logic                     r_out_clip;
    logic                     r_out_last;

    logic                      w_in_acc;
    logic                      w_slot;
    logic                      w_notch_en;
    logic                      w_pre_en;
    t_ch_state                 w_rd;
    logic                      w_rd_ok;
    t_st_wr                    w_wr;
    logic signed [X_W-1:0]     w_x;
    logic signed [X_W:0]       w_x2;
    logic signed [OPND_W-1:0]  w_v;
    logic signed [OPND_W-1:0]  w_bx;
    logic signed [OPND_W-1:0]  w_prev;
    logic signed [RND_W-1:0]   w_rnd_r;
    logic signed [RND_W-1:0]   w_rnd_d;
    logic signed [RND_W-1:0]   w_rnd_p;
    logic signed [STATE_W-1:0] w_z;
    logic signed [O_W-1:0]     w_o;
    logic                      w_clip;
    logic signed [OUT_W-1:0]   w_out;

    // Handshake and stage enables.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_slot     = !r_out_valid || !i_out_stall;
    assign w_notch_en = (r_radius != '0);
    assign w_pre_en   = (r_preemph != '0);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= '0;
            r_denom   <= '0;
            r_preemph <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RADIUS:  r_radius  <= i_cfg_data[COEF15_W-1:0];
                CFG_DENOM:   r_denom   <= i_cfg_data;
                CFG_PREEMPH: r_preemph <= i_cfg_data[COEF15_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mdcnp_chstate u_chstate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_ch (i_mic_channel),
        .o_rd    (w_rd),
        .o_rd_ok (w_rd_ok),
        .i_wr    (w_wr)
    );

    // Widen the sample to Q4.27 and form the notch sums at accept.
    always_comb begin
        w_x    = $signed({i_raw_sample, {X_SHIFT{1'b0}}});
        w_x2   = $signed({w_x, 1'b0});
        w_v    = OPND_W'(w_rd.a) + OPND_W'(w_x);
        w_bx   = OPND_W'(w_rd.b) - OPND_W'(w_x2);
        w_prev = OPND_W'(w_rd.prev);
    end

    mdcnp_dmul u_mul_radius (
        .i_clk   (i_clk),
        .i_load  (w_in_acc),
        .i_step  (r_state == S_MUL),
        .i_opnd  (w_v),
        .i_coef  ({1'b0, r_radius}),
        .o_round (w_rnd_r)
    );

    mdcnp_dmul u_mul_denom (
        .i_clk   (i_clk),
        .i_load  (w_in_acc),
        .i_step  (r_state == S_MUL),
        .i_opnd  (w_v),
        .i_coef  (r_denom),
        .o_round (w_rnd_d)
    );

    mdcnp_dmul u_mul_preemph (
        .i_clk   (i_clk),
        .i_load  (w_in_acc),
        .i_step  (r_state == S_MUL),
        .i_opnd  (w_prev),
        .i_coef  ({1'b0, r_preemph}),
        .o_round (w_rnd_p)
    );

    // Sequencer: accept, one step per coefficient digit, then the finishing stages.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_dcnt == DCNT_W'(DIGITS - 1)) begin
                    n_state = S_FIN1;
                end
            end
            S_FIN1: n_state = S_FIN2;
            S_FIN2: n_state = S_FIN3;
            S_FIN3: n_state = S_FIN4;
            S_FIN4: begin
                if (w_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL) begin
                r_dcnt <= r_dcnt + 1'b1;
            end else begin
                r_dcnt <= '0;
            end
        end
    end

    // Item fields and notch sums captured at accept.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ch   <= i_mic_channel;
            r_last <= i_block_last;
            r_chv  <= w_rd_ok;
            r_x    <= w_x;
            r_bx   <= w_bx;
        end
    end

    // Pre-emphasis result and the output rounding to Q3.20.
    always_comb begin
        if (w_pre_en) begin
            w_z = f_sat_state(SAT_IN_W'(r_y) - SAT_IN_W'(r_pr));
        end else begin
            w_z = r_y;
        end
        w_o    = O_W'($signed(r_z[STATE_W-1:Z_SHIFT]))
               + $signed({{(O_W-1){1'b0}}, r_z[Z_SHIFT-1]});
        w_clip = !((&w_o[O_W-1:OUT_W-1]) || (~|w_o[O_W-1:OUT_W-1]));
        if (!w_clip) begin
            w_out = w_o[OUT_W-1:0];
        end else if (w_o[O_W-1]) begin
            w_out = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_out = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // Finishing stages: rounded products, notch update, pre-emphasis.
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN1) begin
            r_yr <= w_rnd_r;
            r_dr <= w_rnd_d;
            r_pr <= w_rnd_p;
        end
        if (r_state == S_FIN2) begin
            r_na <= f_sat_state(SAT_IN_W'(r_bx) + SAT_IN_W'($signed({r_yr, 1'b0})));
            r_nb <= f_sat_state(SAT_IN_W'(r_x) - SAT_IN_W'(r_dr));
            if (w_notch_en) begin
                r_y <= f_sat_state(SAT_IN_W'(r_yr));
            end else begin
                r_y <= STATE_W'(r_x);
            end
        end
        if (r_state == S_FIN3) begin
            r_z <= w_z;
        end
    end

    // State write-back; a disabled stage or an unknown channel keeps its state.
    always_comb begin
        w_wr.we_notch  = (r_state == S_FIN3) && w_notch_en && r_chv;
        w_wr.we_pre    = (r_state == S_FIN3) && w_pre_en && r_chv;
        w_wr.ch        = r_ch;
        w_wr.data.a    = r_na;
        w_wr.data.b    = r_nb;
        w_wr.data.prev = r_y;
    end

    // Output register: loads when free or being emptied this cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN4) && w_slot) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN4) && w_slot) begin
            r_out_ch     <= r_ch;
            r_out_sample <= w_out;
            r_out_clip   <= w_clip;
            r_out_last   <= r_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_out_ch;
    assign o_clean_sample   = r_out_sample;
    assign o_clipped        = r_out_clip;
    assign o_out_block_last = r_out_last;

endmodule
